// File: src/sbr_pkg.sv
// ----------------------------------------------------------------------------
// sbr_pkg: shared types and constants for the spectral brightness block
// Item layouts, divider request, sequencer states and fixed field widths.
// ----------------------------------------------------------------------------
package sbr_pkg;

	localparam int MAG_W       = 16;  // magnitude field width
	localparam int CUT_W       = 12;  // cutoff register width
	localparam int SUM_W       = 44;  // band sum width
	localparam int BRIGHT_W    = 17;  // brightness width, Q0.16 plus the 1.0 code
	localparam int RATIO_W     = 32;  // high to low ratio width, Q16.16
	localparam int FRAC_W      = 16;  // fraction bits of both quotients
	localparam int DIV_W       = SUM_W + 1;  // divisor and remainder width
	localparam int DIV_BITS    = 32;  // widest quotient the divider produces
	localparam int CNT_W       = 6;   // divider step counter width
	localparam int BRIGHT_STEPS = 17;
	localparam int RATIO_STEPS  = 32;

	typedef struct packed {
		logic [MAG_W-1:0] magnitude;
		logic             last_bin;
	} bin_item_t;

	typedef struct packed {
		logic [BRIGHT_W-1:0] brightness;
		logic [RATIO_W-1:0]  high_to_low;
		logic [SUM_W-1:0]    low_energy;
		logic [SUM_W-1:0]    high_energy;
	} res_item_t;

	typedef struct packed {
		logic                start;
		logic [DIV_W-1:0]    rem;
		logic [DIV_BITS-1:0] bits;
		logic [DIV_W-1:0]    divisor;
		logic [CNT_W-1:0]    count;
	} div_req_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ADD,
		ST_BR_INIT,
		ST_BR_RUN,
		ST_RT_INIT,
		ST_RT_RUN,
		ST_DONE
	} sbr_state_t;

endpackage

// File: src/sbr_accum.sv
// ----------------------------------------------------------------------------
// sbr_accum: squared magnitude band accumulator
// Squares one magnitude into a register, then adds it with saturation to the
// low or the high band sum.
// ----------------------------------------------------------------------------
module sbr_accum import sbr_pkg::*; #(
	parameter int MAGW = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             low_sel,
	input  logic [MAGW-1:0]  mag,
	input  logic             clear,
	output logic [SUM_W-1:0] low_sum,
	output logic [SUM_W-1:0] high_sum
);

	logic                vld_s1;
	logic                sel_s1;
	logic [2*MAGW-1:0]   energy_s1;
	logic [SUM_W-1:0]    low_q;
	logic [SUM_W-1:0]    high_q;
	logic [SUM_W:0]      base;
	logic [SUM_W:0]      sum;
	logic [SUM_W-1:0]    sat;

	always_ff @(posedge clk) begin
		energy_s1 <= mag * mag;
		sel_s1    <= low_sel;
	end

	// One adder serves both bands; the selected sum is the other operand.
	always_comb begin
		base = {1'b0, (sel_s1 ? low_q : high_q)};
		sum  = base + (SUM_W+1)'(energy_s1);
		sat  = sum[SUM_W] ? {SUM_W{1'b1}} : sum[SUM_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			low_q  <= '0;
			high_q <= '0;
		end else begin
			vld_s1 <= en;
			if (clear) begin
				low_q  <= '0;
				high_q <= '0;
			end else if (vld_s1) begin
				if (sel_s1) begin
					low_q <= sat;
				end else begin
					high_q <= sat;
				end
			end
		end
	end

	assign low_sum  = low_q;
	assign high_sum = high_q;

endmodule

// File: src/sbr_divider.sv
// ----------------------------------------------------------------------------
// sbr_divider: shared restoring divider
// Produces one quotient bit per cycle from a preloaded partial remainder and
// the remaining numerator bits, most significant first.
// ----------------------------------------------------------------------------
module sbr_divider import sbr_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  div_req_t            req,
	output logic                busy,
	output logic [DIV_BITS-1:0] quot
);

	logic                busy_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [DIV_W-1:0]    rem_q;
	logic [DIV_BITS-1:0] bits_q;
	logic [DIV_W-1:0]    dvs_q;
	logic [DIV_BITS-1:0] quot_q;
	logic [DIV_W:0]      trial;
	logic [DIV_W:0]      diff;
	logic                fits;

	// The remainder stays below the divisor, so the difference fits DIV_W bits.
	always_comb begin
		trial = {rem_q, bits_q[DIV_BITS-1]};
		diff  = trial - {1'b0, dvs_q};
		fits  = trial >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.count;
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= req.rem;
			bits_q <= req.bits;
			dvs_q  <= req.divisor;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
			bits_q <= {bits_q[DIV_BITS-2:0], 1'b0};
			quot_q <= {quot_q[DIV_BITS-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = quot_q;

endmodule

// File: src/spectral_brightness_ratio.sv
// ----------------------------------------------------------------------------
// spectral_brightness_ratio: spectral brightness and high to low band ratio
// Accumulates squared magnitude bins into two band sums split at a cutoff bin
// and, on the last bin of a frame, divides them into the brightness and the
// high to low ratio.
// ----------------------------------------------------------------------------
// Bins: a new bin is taken only after the last one is squared, then added with
// saturation; bin_stall also holds bins off while a frame's divisions run.
// Result: after a frame's last bin, the shared one-bit-per-cycle divider works out
// 17 brightness and then 32 ratio quotient bits, then res_valid rises with the
// result. A division is skipped for a zero divisor or a saturated ratio.
// Reset clears the sums, the bin counter, the cutoff register and the result valid flag.
module spectral_brightness_ratio import sbr_pkg::*; #(
	parameter int MAX_BINS = 4096,
	parameter int MAG_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             bin_valid,
	output logic             bin_stall,
	input  bin_item_t        bin_item,
	output logic             res_valid,
	input  logic             res_stall,
	output res_item_t        res_item,
	input  logic             cfg_we,
	input  logic [CUT_W-1:0] cfg_data
);

	// The bin counter is as wide as the frame length needs; the cutoff compare
	// runs at the wider of the counter and the cutoff register.
	localparam int POS_W   = $clog2(MAX_BINS);
	localparam int CMP_W   = (POS_W > CUT_W) ? POS_W : CUT_W;
	localparam int MAG_USE = (MAG_BITS < MAG_W) ? MAG_BITS : MAG_W;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_BINS - 1);

	sbr_state_t          state_q;
	sbr_state_t          state_d;
	logic [POS_W-1:0]    pos_q;
	logic [CUT_W-1:0]    cutoff_q;
	logic                last_q;
	logic [BRIGHT_W-1:0] bright_q;
	logic [RATIO_W-1:0]  ratio_q;
	logic                res_valid_q;
	res_item_t           res_item_q;

	logic                acc_en;
	logic                acc_clear;
	logic                low_sel;
	logic [SUM_W-1:0]    low_sum;
	logic [SUM_W-1:0]    high_sum;
	logic [DIV_W-1:0]    total;
	logic                ratio_ovf;
	logic                take_res;
	div_req_t            div_req;
	logic                div_busy;
	logic [DIV_BITS-1:0] div_quot;

	// A bin at or below the cutoff position belongs to the low band.
	assign low_sel = CMP_W'(pos_q) <= CMP_W'(cutoff_q);

	// Both band sums together; a nonzero total is the brightness divisor.
	assign total = {1'b0, low_sum} + {1'b0, high_sum};

	// The ratio saturates when high * 2^16 / low would not fit in 32 bits,
	// which is exactly when high reaches low * 2^16.
	assign ratio_ovf = (SUM_W+FRAC_W)'(high_sum) >= {low_sum, {FRAC_W{1'b0}}};

	sbr_accum #(
		.MAGW(MAG_USE)
	) u_accum (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (acc_en),
		.low_sel  (low_sel),
		.mag      (bin_item.magnitude[MAG_USE-1:0]),
		.clear    (acc_clear),
		.low_sum  (low_sum),
		.high_sum (high_sum)
	);

	sbr_divider u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.busy   (div_busy),
		.quot   (div_quot)
	);

	// Sequencer. Each bin is squared and added; the last bin of a frame then
	// runs the brightness division and the ratio division through the one
	// divider. Both divisions start from a partial remainder that is already
	// below the divisor, so only the quotient bits that can be set are worked
	// out: 17 for the brightness (it never exceeds 1.0) and 32 for the ratio
	// once its saturation has been ruled out.
	always_comb begin
		state_d   = state_q;
		acc_en    = 1'b0;
		acc_clear = 1'b0;
		take_res  = 1'b0;
		div_req   = '0;
		bin_stall = (state_q != ST_IDLE);
		unique case (state_q)
			ST_IDLE: begin
				if (bin_valid) begin
					acc_en  = 1'b1;
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = last_q ? ST_BR_INIT : ST_IDLE;
			end
			ST_BR_INIT: begin
				if (total == '0) begin
					state_d = ST_RT_INIT;
				end else begin
					div_req.start   = 1'b1;
					div_req.rem     = DIV_W'(high_sum >> 1);
					div_req.bits    = {high_sum[0], {(DIV_BITS-1){1'b0}}};
					div_req.divisor = total;
					div_req.count   = CNT_W'(BRIGHT_STEPS);
					state_d         = ST_BR_RUN;
				end
			end
			ST_BR_RUN: begin
				if (!div_busy) begin
					state_d = ST_RT_INIT;
				end
			end
			ST_RT_INIT: begin
				if (low_sum == '0 || ratio_ovf) begin
					state_d = ST_DONE;
				end else begin
					div_req.start   = 1'b1;
					div_req.rem     = DIV_W'(high_sum >> FRAC_W);
					div_req.bits    = {high_sum[FRAC_W-1:0], {(DIV_BITS-FRAC_W){1'b0}}};
					div_req.divisor = DIV_W'(low_sum);
					div_req.count   = CNT_W'(RATIO_STEPS);
					state_d         = ST_RT_RUN;
				end
			end
			ST_RT_RUN: begin
				if (!div_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// The result register must be free or emptying this cycle.
				if (!res_valid_q || !res_stall) begin
					take_res  = 1'b1;
					acc_clear = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			pos_q       <= '0;
			cutoff_q    <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cutoff_q <= cfg_data;
			end
			// The position restarts after the last bin and holds at the
			// final position of an overlong frame.
			if (acc_en) begin
				if (bin_item.last_bin) begin
					pos_q <= '0;
				end else if (pos_q != POS_MAX) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
			if (take_res) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_en) begin
			last_q <= bin_item.last_bin;
		end
		if (state_q == ST_BR_INIT && total == '0) begin
			bright_q <= '0;
		end else if (state_q == ST_BR_RUN && !div_busy) begin
			bright_q <= div_quot[BRIGHT_W-1:0];
		end
		if (state_q == ST_RT_INIT && low_sum == '0) begin
			ratio_q <= '0;
		end else if (state_q == ST_RT_INIT && ratio_ovf) begin
			ratio_q <= {RATIO_W{1'b1}};
		end else if (state_q == ST_RT_RUN && !div_busy) begin
			ratio_q <= div_quot[RATIO_W-1:0];
		end
		if (take_res) begin
			res_item_q.brightness  <= bright_q;
			res_item_q.high_to_low <= ratio_q;
			res_item_q.low_energy  <= low_sum;
			res_item_q.high_energy <= high_sum;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

endmodule

// File: src/sbr_checker.sv
// ----------------------------------------------------------------------------
// sbr_checker: port level checks for the spectral brightness block
// Watches the result channel and the bin handshake over time.
// ----------------------------------------------------------------------------
module sbr_checker import sbr_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      bin_valid,
	input logic      bin_stall,
	input logic      res_valid,
	input logic      res_stall,
	input res_item_t res_item
);

	// A stalled result item stays put.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_item))
		else $error("result item changed while stalled");

	// A bin just taken is squared and added first, so it blocks the next.
	a_bin_gap: assert property (@(posedge clk) disable iff (!arst_n)
		bin_valid && !bin_stall |=> bin_stall)
		else $error("bin item taken on consecutive cycles");

	// Brightness never exceeds 1.0.
	a_bright_max: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res_item.brightness <= BRIGHT_W'(65536))
		else $error("brightness above 1.0");

	// No high band energy means zero brightness and zero ratio.
	a_high_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.high_energy == '0 |->
			res_item.brightness == '0 && res_item.high_to_low == '0)
		else $error("nonzero quotient with empty high band");

	// An empty low band gives a zero ratio.
	a_low_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_item.low_energy == '0 |-> res_item.high_to_low == '0)
		else $error("nonzero ratio with empty low band");

endmodule

bind spectral_brightness_ratio sbr_checker u_sbr_checker (.*);
